// ===== rtl/i2c_register_master_top_assert.svh =====
// Assertion macros for the I2C register master.
// Included by the RTL files that carry concurrent assertions.
`ifndef I2C_REGISTER_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_MASTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define IRM_ASSERT_IMPL(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("i2c register master: assertion failed");

// next-cycle implication
`define IRM_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("i2c register master: assertion failed");

`else

`define IRM_ASSERT_IMPL(name, clk, rst_n, cond, expr)
`define IRM_ASSERT_NEXT(name, clk, rst_n, cond, expr)

`endif

`endif

// ===== rtl/irm_pkg.sv =====
// Types and constants shared by the I2C register master.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irm_pkg;

    // operation codes on the request channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // completion status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NOT_HIGH  = 3'd1;
    localparam logic [2:0] STATUS_NOT_LOW   = 3'd2;
    localparam logic [2:0] STATUS_ADDR_NACK = 3'd3;
    localparam logic [2:0] STATUS_DATA_NACK = 3'd4;

    // R/W bit appended to the device address
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    localparam int LEN_W          = 5;
    localparam int CMD_FIFO_DEPTH = 2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [6:0]       dev_address;
        logic [7:0]       reg_address;
        logic [LEN_W-1:0] length;
        logic [7:0]       data_byte;
        logic             check_data_ack;
        logic             sda_in;
    } req_item_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [2:0] status;
        logic       busy_res;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_LOAD,
        CMD_BEGIN_WR,
        CMD_BEGIN_RD
    } cmd_kind_t;

    // classified command handed from the front end to the engine
    typedef struct packed {
        cmd_kind_t        kind;
        logic [14:0]      target;   // device in 14:8, register in 7:0
        logic [LEN_W-1:0] count;    // clamped to the buffer depth for writes
        logic [7:0]       data;
        logic             chk;
        logic             sda;
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_WR,
        MODE_WR_CHK,
        MODE_RD
    } mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_SEND_DEV,
        S_ACK_DEV,
        S_SEND_REG,
        S_ACK_REG,
        S_SEND_DNC,
        S_ACK_DNC,
        S_SEND_DC,
        S_ACK_DC,
        S_RSTART,
        S_SEND_AR,
        S_ACK_AR,
        S_RECV,
        S_MACK,
        S_STOP_OK,
        S_STOP_AN,
        S_STOP_DN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_register_master_top.sv =====
// Top level of the I2C register master: front end, command queue, bus engine.
// Depends on irm_pkg, irm_front, irm_cmd_fifo and irm_engine.
`timescale 1ns / 1ps
`default_nettype none

// Open-drain I2C master for register writes and reads, stepped one bus phase per
// tick beat. Every request beat (tick, buffer load, begin write, begin read) yields
// exactly one response beat carrying the SCL/SDA levels after that beat, any received
// byte, completion and status. Throughput is one beat per clock while neither side
// stalls: the sequencer does a full phase update on every accepted beat, and a
// two-entry command queue plus a registered response stage let either side stall
// alone. Write data sits in a BUFFER_DEPTH-entry buffer with a registered read port
// that prefetches the next byte.
module i2c_register_master_top #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire irm_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output irm_pkg::rsp_item_t      rsp
);
    import irm_pkg::*;

    cmd_t front_cmd;
    logic front_valid, front_ready;
    cmd_t queue_cmd;
    logic queue_valid, queue_ready;

    irm_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    irm_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    irm_engine #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/irm_cmd_fifo.sv =====
// Short command queue between the front end and the bus engine.
// Depends on irm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irm_cmd_fifo (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire irm_pkg::cmd_t push_cmd,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output irm_pkg::cmd_t     pop_cmd
);
    import irm_pkg::*;

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_FIFO_DEPTH);

    cmd_t             entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/irm_front.sv =====
// Front end: takes request beats and classifies them into engine commands.
// Depends on irm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irm_front #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire irm_pkg::req_item_t req,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output irm_pkg::cmd_t          cmd
);
    import irm_pkg::*;

    localparam int LEN_TOP = (1 << LEN_W) - 1;
    // a write never runs past the buffer
    localparam logic [LEN_W-1:0] WR_LEN_MAX =
        LEN_W'((BUFFER_DEPTH > LEN_TOP) ? LEN_TOP : BUFFER_DEPTH);

    logic [LEN_W-1:0] wr_len;

    assign wr_len    = (req.length > WR_LEN_MAX) ? WR_LEN_MAX : req.length;
    assign cmd_valid = req_valid;
    assign req_ready = cmd_ready;

    always_comb
    begin
        cmd.target = {req.dev_address, req.reg_address};
        cmd.data   = req.data_byte;
        cmd.chk    = req.check_data_ack;
        cmd.sda    = req.sda_in;
        cmd.count  = req.length;
        unique case (req.operation)
            OP_TICK:  cmd.kind = CMD_TICK;
            OP_LOAD:  cmd.kind = CMD_LOAD;
            OP_WRITE:
            begin
                cmd.kind  = CMD_BEGIN_WR;
                cmd.count = wr_len;
            end
            OP_READ:  cmd.kind = CMD_BEGIN_RD;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/irm_engine.sv =====
// Bus engine: transaction sequencer, write buffer and registered result beat.
// Depends on irm_pkg and i2c_register_master_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_register_master_top_assert.svh"

module irm_engine #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire irm_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output irm_pkg::rsp_item_t rsp
);
    import irm_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(BUFFER_DEPTH);
    localparam logic [AW-1:0] RPTR_LAST = AW'(BUFFER_DEPTH - 1);

    function automatic state_t ack_after(input state_t s);
        state_t r;
        unique case (s)
            S_SEND_DEV: r = S_ACK_DEV;
            S_SEND_REG: r = S_ACK_REG;
            S_SEND_DNC: r = S_ACK_DNC;
            S_SEND_DC:  r = S_ACK_DC;
            default:    r = S_ACK_AR;
        endcase
        return r;
    endfunction

    state_t           st_reg, st_next;
    mode_t            mode_reg, mode_next;
    logic [1:0]       ph_reg, ph_next;
    logic [3:0]       bc_reg, bc_next;
    logic [7:0]       sh_reg, sh_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [14:0]      target_reg, target_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [7:0]       rdata_reg;
    logic [7:0]       mem [BUFFER_DEPTH];

    logic             out_valid_reg;
    rsp_item_t        out_reg;
    rsp_item_t        out_next;

    logic             pop;
    logic             mem_we;
    logic             chain;
    logic             wr_mode;
    logic [3:0]       bc_inc;
    logic [7:0]       sh_in;
    logic [LEN_W-1:0] cnt_dec;
    logic [AW-1:0]    rptr_inc;
    logic [6:0]       dev;
    logic             rd_valid;
    logic [7:0]       rd_byte;
    logic             done;
    logic [2:0]       status;

    assign cmd_ready = !out_valid_reg || rsp_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign wr_mode  = (mode_reg != MODE_RD);
    assign bc_inc   = bc_reg + 4'd1;
    assign sh_in    = {sh_reg[6:0], cmd.sda};
    assign cnt_dec  = cnt_reg - 1'b1;
    assign rptr_inc = (rptr_reg == RPTR_LAST) ? '0 : rptr_reg + 1'b1;
    assign dev      = target_reg[14:8];

    always_comb
    begin
        st_next     = st_reg;
        mode_next   = mode_reg;
        ph_next     = ph_reg;
        bc_next     = bc_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        target_next = target_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        rptr_next   = rptr_reg;
        mem_we      = 1'b0;
        chain       = 1'b0;
        rd_valid    = 1'b0;
        rd_byte     = '0;
        done        = 1'b0;
        status      = STATUS_OK;

        if (pop)
        begin
            unique case (cmd.kind)
                CMD_TICK:
                begin
                    if (st_reg != S_IDLE)
                    begin
                        unique case (st_reg)
                            S_START:
                            begin
                                unique case (ph_reg)
                                    2'd0:
                                    begin
                                        sda_next = 1'b1;
                                        scl_next = 1'b1;
                                        ph_next  = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        if (!cmd.sda)
                                        begin
                                            st_next = S_IDLE;
                                            ph_next = 2'd0;
                                            done    = 1'b1;
                                            status  = STATUS_NOT_HIGH;
                                            if (wr_mode)
                                            begin
                                                fill_next = '0;
                                            end
                                        end
                                        else
                                        begin
                                            sda_next = 1'b0;
                                            ph_next  = 2'd2;
                                        end
                                    end
                                    default:
                                    begin
                                        if (cmd.sda)
                                        begin
                                            st_next = S_IDLE;
                                            ph_next = 2'd0;
                                            done    = 1'b1;
                                            status  = STATUS_NOT_LOW;
                                            if (wr_mode)
                                            begin
                                                fill_next = '0;
                                            end
                                        end
                                        else
                                        begin
                                            sda_next = 1'b0;
                                            st_next  = S_SEND_DEV;
                                            sh_next  = {dev, RW_WRITE};
                                            bc_next  = '0;
                                            ph_next  = 2'd0;
                                        end
                                    end
                                endcase
                            end

                            S_SEND_DEV, S_SEND_REG, S_SEND_DNC, S_SEND_DC, S_SEND_AR:
                            begin
                                unique case (ph_reg)
                                    2'd0:
                                    begin
                                        scl_next = 1'b0;
                                        ph_next  = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        sda_next = sh_reg[7];
                                        sh_next  = {sh_reg[6:0], 1'b0};
                                        ph_next  = 2'd2;
                                    end
                                    default:
                                    begin
                                        scl_next = 1'b1;
                                        ph_next  = 2'd0;
                                        bc_next  = bc_inc;
                                        if (bc_inc >= 4'd8)
                                        begin
                                            st_next = ack_after(st_reg);
                                        end
                                    end
                                endcase
                            end

                            S_ACK_DEV, S_ACK_REG, S_ACK_DNC, S_ACK_DC, S_ACK_AR:
                            begin
                                if (ph_reg != 2'd3)
                                begin
                                    unique case (ph_reg)
                                        2'd0:    scl_next = 1'b0;
                                        2'd1:    sda_next = 1'b1;
                                        default: scl_next = 1'b1;
                                    endcase
                                    ph_next = ph_reg + 2'd1;
                                end
                                else
                                begin
                                    // sample slot; the follow-on state starts this beat
                                    chain   = 1'b1;
                                    ph_next = 2'd0;
                                    unique case (st_reg)
                                        S_ACK_DEV:
                                        begin
                                            if (cmd.sda)
                                            begin
                                                st_next = S_STOP_AN;
                                                if (wr_mode)
                                                begin
                                                    fill_next = '0;
                                                end
                                            end
                                            else
                                            begin
                                                st_next = S_SEND_REG;
                                                sh_next = target_reg[7:0];
                                                bc_next = '0;
                                            end
                                        end
                                        S_ACK_REG:
                                        begin
                                            if (mode_reg == MODE_RD)
                                            begin
                                                st_next = S_RSTART;
                                            end
                                            else if (cnt_reg == '0)
                                            begin
                                                st_next   = S_STOP_OK;
                                                fill_next = '0;
                                            end
                                            else
                                            begin
                                                st_next   = (mode_reg == MODE_WR_CHK) ?
                                                            S_SEND_DC : S_SEND_DNC;
                                                sh_next   = rdata_reg;
                                                bc_next   = '0;
                                                rptr_next = rptr_inc;
                                            end
                                        end
                                        S_ACK_DNC, S_ACK_DC:
                                        begin
                                            if (cmd.sda && st_reg == S_ACK_DC)
                                            begin
                                                st_next   = S_STOP_DN;
                                                fill_next = '0;
                                            end
                                            else
                                            begin
                                                cnt_next = cnt_dec;
                                                if (cnt_dec == '0)
                                                begin
                                                    st_next   = S_STOP_OK;
                                                    fill_next = '0;
                                                end
                                                else
                                                begin
                                                    st_next   = (st_reg == S_ACK_DC) ?
                                                                S_SEND_DC : S_SEND_DNC;
                                                    sh_next   = rdata_reg;
                                                    bc_next   = '0;
                                                    rptr_next = rptr_inc;
                                                end
                                            end
                                        end
                                        default:
                                        begin
                                            if (cnt_reg == '0)
                                            begin
                                                st_next = S_STOP_OK;
                                            end
                                            else
                                            begin
                                                st_next = S_RECV;
                                                sh_next = '0;
                                                bc_next = '0;
                                            end
                                        end
                                    endcase
                                end
                            end

                            S_RSTART:
                            begin
                                unique case (ph_reg)
                                    2'd0:
                                    begin
                                        sda_next = 1'b1;
                                        scl_next = 1'b1;
                                        ph_next  = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        if (!cmd.sda)
                                        begin
                                            // failed repeated start: go straight to address
                                            st_next = S_SEND_AR;
                                            sh_next = {dev, RW_READ};
                                            bc_next = '0;
                                            ph_next = 2'd0;
                                            chain   = 1'b1;
                                        end
                                        else
                                        begin
                                            sda_next = 1'b0;
                                            ph_next  = 2'd2;
                                        end
                                    end
                                    default:
                                    begin
                                        st_next = S_SEND_AR;
                                        sh_next = {dev, RW_READ};
                                        bc_next = '0;
                                        ph_next = 2'd0;
                                        if (cmd.sda)
                                        begin
                                            chain = 1'b1;
                                        end
                                        else
                                        begin
                                            sda_next = 1'b0;
                                        end
                                    end
                                endcase
                            end

                            S_RECV:
                            begin
                                unique case (ph_reg)
                                    2'd0:
                                    begin
                                        if (bc_reg == '0)
                                        begin
                                            sda_next = 1'b1;
                                        end
                                        scl_next = 1'b0;
                                        ph_next  = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        scl_next = 1'b1;
                                        ph_next  = 2'd2;
                                    end
                                    default:
                                    begin
                                        sh_next = sh_in;
                                        bc_next = bc_inc;
                                        ph_next = 2'd0;
                                        chain   = 1'b1;
                                        if (bc_inc >= 4'd8)
                                        begin
                                            rd_valid = 1'b1;
                                            rd_byte  = sh_in;
                                            st_next  = S_MACK;
                                        end
                                    end
                                endcase
                            end

                            S_MACK:
                            begin
                                unique case (ph_reg)
                                    2'd0:
                                    begin
                                        scl_next = 1'b0;
                                        ph_next  = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        // NACK the last byte, ACK the rest
                                        sda_next = (cnt_reg == LEN_W'(1));
                                        ph_next  = 2'd2;
                                    end
                                    2'd2:
                                    begin
                                        scl_next = 1'b1;
                                        ph_next  = 2'd3;
                                    end
                                    default:
                                    begin
                                        scl_next = 1'b0;
                                        cnt_next = cnt_dec;
                                        ph_next  = 2'd0;
                                        if (cnt_dec == '0)
                                        begin
                                            st_next = S_STOP_OK;
                                        end
                                        else
                                        begin
                                            st_next = S_RECV;
                                            sh_next = '0;
                                            bc_next = '0;
                                        end
                                    end
                                endcase
                            end

                            S_STOP_OK, S_STOP_AN, S_STOP_DN:
                            begin
                                unique case (ph_reg)
                                    2'd0:
                                    begin
                                        scl_next = 1'b0;
                                        ph_next  = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        sda_next = 1'b0;
                                        ph_next  = 2'd2;
                                    end
                                    2'd2:
                                    begin
                                        scl_next = 1'b1;
                                        ph_next  = 2'd3;
                                    end
                                    default:
                                    begin
                                        sda_next = 1'b1;
                                        st_next  = S_IDLE;
                                        ph_next  = 2'd0;
                                        done     = 1'b1;
                                        if (st_reg == S_STOP_AN)
                                        begin
                                            status = STATUS_ADDR_NACK;
                                        end
                                        else if (st_reg == S_STOP_DN)
                                        begin
                                            status = STATUS_DATA_NACK;
                                        end
                                    end
                                endcase
                            end

                            default:
                            begin
                                st_next = S_IDLE;
                                ph_next = 2'd0;
                            end
                        endcase

                        // first phase of the state entered on an acknowledge or bit sample
                        if (chain)
                        begin
                            unique case (st_next)
                                S_SEND_DEV, S_SEND_REG, S_SEND_DNC, S_SEND_DC, S_SEND_AR,
                                S_STOP_OK, S_STOP_AN, S_STOP_DN, S_MACK:
                                begin
                                    scl_next = 1'b0;
                                    ph_next  = 2'd1;
                                end
                                S_RECV:
                                begin
                                    if (bc_next == '0)
                                    begin
                                        sda_next = 1'b1;
                                    end
                                    scl_next = 1'b0;
                                    ph_next  = 2'd1;
                                end
                                S_RSTART:
                                begin
                                    sda_next = 1'b1;
                                    scl_next = 1'b1;
                                    ph_next  = 2'd1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end

                CMD_LOAD:
                begin
                    if (st_reg == S_IDLE && fill_reg < FILL_MAX)
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end

                CMD_BEGIN_WR:
                begin
                    if (st_reg == S_IDLE)
                    begin
                        target_next = cmd.target;
                        ph_next     = 2'd0;
                        bc_next     = '0;
                        fill_next   = FW'(cmd.count);
                        cnt_next    = cmd.count;
                        rptr_next   = '0;
                        st_next     = S_START;
                        mode_next   = cmd.chk ? MODE_WR_CHK : MODE_WR;
                    end
                end

                CMD_BEGIN_RD:
                begin
                    if (st_reg == S_IDLE)
                    begin
                        target_next = cmd.target;
                        ph_next     = 2'd0;
                        bc_next     = '0;
                        cnt_next    = cmd.count;
                        st_next     = S_START;
                        mode_next   = MODE_RD;
                    end
                end
            endcase
        end

        out_next.scl_drive  = scl_next;
        out_next.sda_drive  = sda_next;
        out_next.read_valid = rd_valid;
        out_next.read_byte  = rd_byte;
        out_next.done_res   = done;
        out_next.status     = status;
        out_next.busy_res   = (st_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            mode_reg      <= MODE_WR;
            ph_reg        <= '0;
            bc_reg        <= '0;
            sh_reg        <= '0;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            target_reg    <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            mode_reg   <= mode_next;
            ph_reg     <= ph_next;
            bc_reg     <= bc_next;
            sh_reg     <= sh_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
            target_reg <= target_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            rptr_reg   <= rptr_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    // write buffer; the next data byte is read ahead into rdata_reg
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fill_reg[AW-1:0]] <= cmd.data;
        end
        rdata_reg <= mem[rptr_reg];
    end

    `IRM_ASSERT_IMPL(a_byte_not_done, clk, rst_n, out_valid_reg && out_reg.read_valid, !out_reg.done_res)
    `IRM_ASSERT_IMPL(a_done_not_busy, clk, rst_n, out_valid_reg && out_reg.done_res, !out_reg.busy_res)
    `IRM_ASSERT_IMPL(a_status_on_done, clk, rst_n, out_valid_reg && !out_reg.done_res, out_reg.status == STATUS_OK)
    `IRM_ASSERT_IMPL(a_idle_phase, clk, rst_n, st_reg == S_IDLE, ph_reg == 2'd0)
    `IRM_ASSERT_NEXT(a_load_fills, clk, rst_n, pop && cmd.kind == CMD_LOAD && st_reg == S_IDLE, fill_reg != '0)

endmodule

`default_nettype wire
